// ----- hw/rtl/mrs_pkg.sv -----
// ----------------------------------------------------------------------------
// mrs_pkg
// Shared types, codes and descriptor layout for the message reassembly block.
// ----------------------------------------------------------------------------
package mrs_pkg;

	// Default sizing
	localparam int NUM_SLOTS_DEF = 16;
	localparam int MAX_WORDS_DEF = 32;

	// Descriptor layout
	localparam int DESC_BEGIN_OFF = 0;
	localparam int DESC_END_OFF   = 1;
	localparam int DESC_LEN_OFF   = 5;
	localparam int DESC_LEN_W     = 3;
	localparam int DESC_ID_OFF    = 8;
	localparam int DESC_ID_W      = 56;

	// Result status codes
	typedef enum logic [2:0] {
		ST_ACCEPTED    = 3'd0,
		ST_DELIVERED   = 3'd1,
		ST_NO_MESSAGE  = 3'd2,
		ST_UNSUPPORTED = 3'd3,
		ST_NO_SLOT     = 3'd4,
		ST_OVERFLOW    = 3'd5
	} status_t;

	// One input packet
	typedef struct packed {
		logic [31:0] service_code;
		logic [63:0] descriptor;
		logic [63:0] word_a;
		logic [63:0] word_b;
		logic [63:0] word_c;
		logic [63:0] word_d;
		logic [63:0] word_e;
		logic [63:0] word_f;
		logic [63:0] word_g;
	} req_t;

	// One result
	typedef struct packed {
		status_t     status;
		logic [63:0] new_descriptor;
		logic        word_valid;
		logic [63:0] message_word;
		logic [4:0]  word_index;
		logic        last;
	} rsp_t;

	// Commands from the sequencer to the slot table
	typedef struct packed {
		logic alloc;    // take new_slot (pop the stack or create)
		logic len_we;   // write the slot length
		logic release_; // free the slot onto the stack
	} tbl_cmd_t;

	// Status from the slot table
	typedef struct packed {
		logic has_free;   // free stack not empty
		logic can_create; // unused slots remain
		logic hit;        // looked-up id names a live slot
	} tbl_stat_t;

	// Select payload word k (0 = word_a)
	function automatic logic [63:0] pick_word(input req_t r, input logic [2:0] k);
		logic [63:0] w;
		case (k)
			3'd0: w = r.word_a;
			3'd1: w = r.word_b;
			3'd2: w = r.word_c;
			3'd3: w = r.word_d;
			3'd4: w = r.word_e;
			3'd5: w = r.word_f;
			3'd6: w = r.word_g;
			default: w = r.word_a;
		endcase
		return w;
	endfunction

endpackage

// ----- hw/rtl/mrs_word_store.sv -----
// ----------------------------------------------------------------------------
// mrs_word_store
// Message word memory: one row of MAX_WORDS entries per slot, one write and
// one registered read per cycle.
// ----------------------------------------------------------------------------
module mrs_word_store #(
	parameter int NUM_SLOTS = mrs_pkg::NUM_SLOTS_DEF,
	parameter int MAX_WORDS = mrs_pkg::MAX_WORDS_DEF,
	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
	localparam int IW = $clog2(MAX_WORDS)
) (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic [SW-1:0]                wr_slot,
	input  logic [IW-1:0]                wr_idx,
	input  logic [63:0]                  wr_data,
	input  logic                         rd_en,
	input  logic [SW-1:0]                rd_slot,
	input  logic [IW-1:0]                rd_idx,
	output logic [63:0]                  rd_data
);
	localparam int DEPTH = NUM_SLOTS << IW;

	logic [63:0] mem_q [DEPTH];
	logic [63:0] rd_data_q;

	// Store a word
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[{wr_slot, wr_idx}] <= wr_data;
		end
	end

	// Read a word; hold the data until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[{rd_slot, rd_idx}];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hw/rtl/mrs_slot_table.sv -----
// ----------------------------------------------------------------------------
// mrs_slot_table
// Per-slot bookkeeping: live bits, length memory, LIFO stack of freed slots
// and the count of slots ever created.
// ----------------------------------------------------------------------------
module mrs_slot_table #(
	parameter int NUM_SLOTS = mrs_pkg::NUM_SLOTS_DEF,
	parameter int MAX_WORDS = mrs_pkg::MAX_WORDS_DEF,
	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
	localparam int LW = $clog2(MAX_WORDS + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// lookup, results registered on lk_en
	input  logic                          lk_en,
	input  logic [mrs_pkg::DESC_ID_W-1:0] lk_id,
	output mrs_pkg::tbl_stat_t            stat,
	output logic [LW-1:0]                 cur_len,
	output logic [SW-1:0]                 new_slot,
	// updates
	input  mrs_pkg::tbl_cmd_t             cmd,
	input  logic [SW-1:0]                 cmd_slot,
	input  logic [LW-1:0]                 cmd_len
);
	localparam int CW = $clog2(NUM_SLOTS + 1);

	logic [NUM_SLOTS-1:0] live_q;
	logic [LW-1:0]        len_mem_q [NUM_SLOTS];
	logic [SW-1:0]        stack_mem_q [NUM_SLOTS];
	logic [CW-1:0]        free_count_q;
	logic [CW-1:0]        created_q;
	logic [LW-1:0]        len_rd_q;
	logic [SW-1:0]        stack_rd_q;
	logic                 hit_q;
	logic [CW-1:0]        top_idx;
	logic                 has_free;

	assign has_free = (free_count_q != '0);
	assign top_idx  = free_count_q - CW'(1);

	// Length and stack reads for the packet just taken
	always_ff @(posedge clk) begin
		if (lk_en) begin
			len_rd_q   <= len_mem_q[lk_id[SW-1:0]];
			stack_rd_q <= stack_mem_q[top_idx[SW-1:0]];
		end
	end

	// Length write-back
	always_ff @(posedge clk) begin
		if (cmd.len_we) begin
			len_mem_q[cmd_slot] <= cmd_len;
		end
	end

	// Push a freed slot
	always_ff @(posedge clk) begin
		if (cmd.release_ && (free_count_q < CW'(NUM_SLOTS))) begin
			stack_mem_q[free_count_q[SW-1:0]] <= cmd_slot;
		end
	end

	// Live bits, counters and the lookup hit flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q       <= '0;
			free_count_q <= '0;
			created_q    <= '0;
			hit_q        <= 1'b0;
		end else begin
			if (lk_en) begin
				hit_q <= (lk_id < mrs_pkg::DESC_ID_W'(created_q)) && live_q[lk_id[SW-1:0]];
			end
			if (cmd.alloc) begin
				live_q[cmd_slot] <= 1'b1;
				if (has_free) begin
					free_count_q <= free_count_q - CW'(1);
				end else begin
					created_q <= created_q + CW'(1);
				end
			end
			if (cmd.release_) begin
				live_q[cmd_slot] <= 1'b0;
				if (free_count_q < CW'(NUM_SLOTS)) begin
					free_count_q <= free_count_q + CW'(1);
				end
			end
		end
	end

	assign stat.has_free   = has_free;
	assign stat.can_create = (created_q < CW'(NUM_SLOTS));
	assign stat.hit        = hit_q;
	assign cur_len         = len_rd_q;
	assign new_slot        = has_free ? stack_rd_q : created_q[SW-1:0];

endmodule

// ----- hw/rtl/message_reassembly_slots.sv -----
// ----------------------------------------------------------------------------
// message_reassembly_slots
// Sequence: a packet is evaluated, then its L words are appended (one word
//   per cycle, L being the packet length), then the result is decided and
//   loaded; no slot, no message and overflow go from evaluation to the result.
//   Delivery: each word takes a word memory read, then an output register load,
//   held while the output is stalled. Throughput: one packet at a time; the
//   next transfer can be taken in the cycle after the last result is loaded.
//   Reset clears live bits, free and created counts and the service register;
//   memories need no clearing pass.
module message_reassembly_slots #(
	parameter int NUM_SLOTS = mrs_pkg::NUM_SLOTS_DEF,
	parameter int MAX_WORDS = mrs_pkg::MAX_WORDS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic [31:0]   cfg_wr_data,
	input  logic          req_valid,
	output logic          req_stall,
	input  mrs_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output mrs_pkg::rsp_t rsp
);
	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int IW = $clog2(MAX_WORDS);
	localparam int LW = $clog2(MAX_WORDS + 1);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_EVAL   = 7'b0000010,
		S_APPEND = 7'b0000100,
		S_DECIDE = 7'b0001000,
		S_RESP   = 7'b0010000,
		S_DRD    = 7'b0100000,
		S_DOUT   = 7'b1000000
	} state_t;

	state_t             state_q, state_d;
	logic [31:0]        deliver_code_q;
	mrs_pkg::req_t      item_q;
	logic [SW-1:0]      slot_q, slot_d;
	logic [LW-1:0]      base_q, base_d;
	logic [LW-1:0]      cnt_q, cnt_d;
	logic [LW-1:0]      new_len_q, new_len_d;
	mrs_pkg::status_t   status_q, status_d;
	logic [63:0]        desc_out_q, desc_out_d;
	logic               rel_q, rel_d;
	mrs_pkg::rsp_t      rsp_q, rsp_d;
	logic               rsp_valid_q;
	logic               rsp_load;
	logic               out_free;
	logic               accept;

	mrs_pkg::tbl_stat_t tbl_stat;
	mrs_pkg::tbl_cmd_t  tbl_cmd;
	logic [SW-1:0]      tbl_slot;
	logic [LW-1:0]      tbl_len;
	logic [LW-1:0]      cur_len;
	logic [SW-1:0]      new_slot;

	logic               wr_en, rd_en;
	logic [IW-1:0]      wr_idx;
	logic [LW-1:0]      wr_pos;
	logic [63:0]        rd_data;

	logic               is_begin, is_end;
	logic [2:0]         pkt_len;
	logic [mrs_pkg::DESC_ID_W-1:0] pkt_id;
	logic [LW-1:0]      eval_cur;
	logic [SW-1:0]      eval_slot;
	logic [LW:0]        eval_sum;
	logic [LW-1:0]      cnt_nxt;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign out_free  = !rsp_valid_q || !rsp_stall;

	assign is_begin = item_q.descriptor[mrs_pkg::DESC_BEGIN_OFF];
	assign is_end   = item_q.descriptor[mrs_pkg::DESC_END_OFF];
	assign pkt_len  = item_q.descriptor[mrs_pkg::DESC_LEN_OFF +: mrs_pkg::DESC_LEN_W];
	assign pkt_id   = item_q.descriptor[mrs_pkg::DESC_ID_OFF +: mrs_pkg::DESC_ID_W];
	assign eval_cur  = is_begin ? '0 : cur_len;
	assign eval_slot = is_begin ? new_slot : pkt_id[SW-1:0];
	assign eval_sum  = {1'b0, eval_cur} + (LW + 1)'(pkt_len);
	assign cnt_nxt   = cnt_q + LW'(1);
	assign wr_pos    = base_q + cnt_q;
	assign wr_idx    = wr_pos[IW-1:0];

	// Slot bookkeeping
	mrs_slot_table #(
		.NUM_SLOTS(NUM_SLOTS),
		.MAX_WORDS(MAX_WORDS)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.lk_en   (accept),
		.lk_id   (req.descriptor[mrs_pkg::DESC_ID_OFF +: mrs_pkg::DESC_ID_W]),
		.stat    (tbl_stat),
		.cur_len (cur_len),
		.new_slot(new_slot),
		.cmd     (tbl_cmd),
		.cmd_slot(tbl_slot),
		.cmd_len (tbl_len)
	);

	// Message words
	mrs_word_store #(
		.NUM_SLOTS(NUM_SLOTS),
		.MAX_WORDS(MAX_WORDS)
	) u_words (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_slot(slot_q),
		.wr_idx (wr_idx),
		.wr_data(mrs_pkg::pick_word(item_q, cnt_q[2:0])),
		.rd_en  (rd_en),
		.rd_slot(slot_q),
		.rd_idx (cnt_q[IW-1:0]),
		.rd_data(rd_data)
	);

	// Sequencer
	always_comb begin
		state_d    = state_q;
		slot_d     = slot_q;
		base_d     = base_q;
		cnt_d      = cnt_q;
		new_len_d  = new_len_q;
		status_d   = status_q;
		desc_out_d = desc_out_q;
		rel_d      = rel_q;
		rsp_d      = rsp_q;
		rsp_load   = 1'b0;
		tbl_cmd    = '0;
		tbl_slot   = slot_q;
		tbl_len    = eval_sum[LW-1:0];
		wr_en      = 1'b0;
		rd_en      = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				desc_out_d = item_q.descriptor;
				rel_d      = 1'b0;
				cnt_d      = '0;
				if (is_begin && !tbl_stat.has_free && !tbl_stat.can_create) begin
					status_d = mrs_pkg::ST_NO_SLOT;
					state_d  = S_RESP;
				end else if (!is_begin && !tbl_stat.hit) begin
					status_d = mrs_pkg::ST_NO_MESSAGE;
					state_d  = S_RESP;
				end else begin
					slot_d      = eval_slot;
					tbl_slot    = eval_slot;
					tbl_cmd.alloc = is_begin;
					if (is_begin) begin
						desc_out_d = {mrs_pkg::DESC_ID_W'(eval_slot),
							item_q.descriptor[mrs_pkg::DESC_ID_OFF-1:1], 1'b0};
					end
					if (eval_sum > (LW + 1)'(MAX_WORDS)) begin
						// drop the whole message
						status_d = mrs_pkg::ST_OVERFLOW;
						rel_d    = 1'b1;
						state_d  = S_RESP;
					end else begin
						tbl_cmd.len_we = 1'b1;
						base_d    = eval_cur;
						new_len_d = eval_sum[LW-1:0];
						state_d   = (pkt_len != 3'd0) ? S_APPEND : S_DECIDE;
					end
				end
			end
			S_APPEND: begin
				wr_en = 1'b1;
				cnt_d = cnt_nxt;
				if (cnt_nxt == LW'(pkt_len)) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cnt_d = '0;
				if (!is_end) begin
					status_d = mrs_pkg::ST_ACCEPTED;
					state_d  = S_RESP;
				end else if (item_q.service_code != deliver_code_q) begin
					status_d = mrs_pkg::ST_UNSUPPORTED;
					state_d  = S_RESP;
				end else if (new_len_q == '0) begin
					status_d = mrs_pkg::ST_DELIVERED;
					rel_d    = 1'b1;
					state_d  = S_RESP;
				end else begin
					state_d = S_DRD;
				end
			end
			S_RESP: begin
				if (out_free) begin
					rsp_load             = 1'b1;
					rsp_d.status         = status_q;
					rsp_d.new_descriptor = desc_out_q;
					rsp_d.word_valid     = 1'b0;
					rsp_d.message_word   = '0;
					rsp_d.word_index     = '0;
					rsp_d.last           = 1'b1;
					tbl_cmd.release_     = rel_q;
					state_d              = S_IDLE;
				end
			end
			S_DRD: begin
				rd_en   = 1'b1;
				state_d = S_DOUT;
			end
			S_DOUT: begin
				if (out_free) begin
					rsp_load             = 1'b1;
					rsp_d.status         = mrs_pkg::ST_DELIVERED;
					rsp_d.new_descriptor = desc_out_q;
					rsp_d.word_valid     = 1'b1;
					rsp_d.message_word   = rd_data;
					rsp_d.word_index     = 5'(cnt_q);
					rsp_d.last           = (cnt_nxt == new_len_q);
					cnt_d                = cnt_nxt;
					if (cnt_nxt == new_len_q) begin
						tbl_cmd.release_ = 1'b1;
						state_d          = S_IDLE;
					end else begin
						state_d = S_DRD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			rsp_valid_q    <= 1'b0;
			deliver_code_q <= '0;
		end else begin
			state_q <= state_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				deliver_code_q <= cfg_wr_data;
			end
		end
	end

	// Payload and working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= req;
		end
		slot_q     <= slot_d;
		base_q     <= base_d;
		cnt_q      <= cnt_d;
		new_len_q  <= new_len_d;
		status_q   <= status_d;
		desc_out_q <= desc_out_d;
		rel_q      <= rel_d;
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Checks
	a_word_is_delivery: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.word_valid |-> rsp.status == mrs_pkg::ST_DELIVERED)
		else $error("delivered word without delivered status");

	a_no_word_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.word_valid |-> rsp.last)
		else $error("single result not marked last");

	a_transfer_evaluates: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> state_q == S_EVAL)
		else $error("packet transfer not followed by evaluation");

	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |-> out_free)
		else $error("result loaded over a stalled result");

endmodule
